[design/bps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the block predictor selector: register
// indexes, predictor codes, channel payloads and the front-to-back queue word.
// ----------------------------------------------------------------------------
package bps_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int CFG_DIM_W   = 13;
   localparam int CFG_CHAN_W  = 3;
   localparam int CFG_BLOCK_W = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_CHANNEL_COUNT = 2'd2,
      REG_BLOCK_SIZE    = 2'd3
   } reg_index_type;

   // data widths
   localparam int SAMPLE_W   = 8;
   localparam int SCORE_W    = 23;
   localparam int BLKNUM_W   = 24;
   localparam int FILTER_W   = 3;
   localparam int NUM_PRED   = 6;
   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   // predictor codes
   typedef enum logic [FILTER_W-1:0] {
      FILTER_NONE  = 3'd0,
      FILTER_LEFT  = 3'd1,
      FILTER_UP    = 3'd2,
      FILTER_AVG   = 3'd3,
      FILTER_PAETH = 3'd4,
      FILTER_LOCO  = 3'd5
   } filter_type;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SCORE_W-1:0]  score_type;

   typedef struct packed {
      sample_type raw_sample;
      sample_type left_sample;
      sample_type up_sample;
      sample_type up_left_sample;
   } req_payload_type;

   typedef struct packed {
      logic [FILTER_W-1:0] best_filter;
      logic [BLKNUM_W-1:0] block_number;
      score_type           best_score;
   } rsp_payload_type;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one classified sample, neighbors already zeroed at image borders
   typedef struct packed {
      logic                last_of_block;
      logic [BLKNUM_W-1:0] block_number;
      sample_type          raw_sample;
      sample_type          left_sample;
      sample_type          up_sample;
      sample_type          up_left_sample;
   } queue_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

[design/bps_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bps_stream_if
// Valid/ready stream channel; a word moves at a clock edge where valid and
// ready are both high.
// ----------------------------------------------------------------------------
interface bps_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/bps_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bps_front
// Takes configuration writes and input samples, tracks the sample position
// inside the image, zeroes neighbors outside the image and marks the last
// sample of each block before pushing the word into the queue.
// ----------------------------------------------------------------------------
module bps_front import bps_pkg::*; #(
   parameter int MAX_DIM      = 4096,
   parameter int MAX_BLOCK    = 64,
   parameter int MAX_CHANNELS = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   bps_stream_if.sink                  req_ch,
   input  wire queue_status_type       q_status,
   output logic                        push_valid,
   output queue_word_type              push_word
);

   localparam int DW = $clog2(MAX_DIM);
   localparam int GW = ((DW > CFG_DIM_W) ? DW : CFG_DIM_W) + 1;
   localparam int BW = $clog2(MAX_BLOCK);
   localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int RESET_BLOCK = (MAX_BLOCK < 8) ? MAX_BLOCK : 8;

   // configuration, held already clamped
   logic [CFG_DIM_W-1:0]   width_ff, width_in;
   logic [CFG_DIM_W-1:0]   height_ff, height_in;
   logic [CFG_CHAN_W-1:0]  chan_ff, chan_in;
   logic [CFG_BLOCK_W-1:0] bsize_ff, bsize_in;

   // position
   logic [CW-1:0]       ch_pos_ff, ch_pos_in;
   logic [BW-1:0]       col_ff, col_in;
   logic [BW-1:0]       row_ff, row_in;
   logic [DW-1:0]       org_x_ff, org_x_in;
   logic [DW-1:0]       org_y_ff, org_y_in;
   logic [BLKNUM_W-1:0] blk_cnt_ff, blk_cnt_in;

   logic          accept;
   logic          x_zero, y_zero;
   logic [GW-1:0] w_g, h_g, b_g, ox_g, oy_g;
   logic [GW-1:0] rem_x, rem_y, bw_g, bh_g, nx_g, ny_g;
   logic          last_ch, last_col, last_row, blk_end;
   logic          wrap_x, wrap_y;
   req_payload_type req_word;

   assign req_ch.ready = ~q_status.full;
   assign accept       = req_ch.valid & ~q_status.full;
   assign req_word     = req_payload_type'(req_ch.payload);

   // clamp on write
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      chan_in   = chan_ff;
      bsize_in  = bsize_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH: begin
               if (csr_wdata == '0)
                  width_in = CFG_DIM_W'(1);
               else if (32'(csr_wdata) > MAX_DIM)
                  width_in = CFG_DIM_W'(MAX_DIM);
               else
                  width_in = csr_wdata;
            end
            REG_IMAGE_HEIGHT: begin
               if (csr_wdata == '0)
                  height_in = CFG_DIM_W'(1);
               else if (32'(csr_wdata) > MAX_DIM)
                  height_in = CFG_DIM_W'(MAX_DIM);
               else
                  height_in = csr_wdata;
            end
            REG_CHANNEL_COUNT: begin
               if (csr_wdata[CFG_CHAN_W-1:0] == '0)
                  chan_in = CFG_CHAN_W'(1);
               else if (32'(csr_wdata[CFG_CHAN_W-1:0]) > MAX_CHANNELS)
                  chan_in = CFG_CHAN_W'(MAX_CHANNELS);
               else
                  chan_in = csr_wdata[CFG_CHAN_W-1:0];
            end
            REG_BLOCK_SIZE: begin
               if (csr_wdata[CFG_BLOCK_W-1:0] == '0)
                  bsize_in = CFG_BLOCK_W'(1);
               else if (32'(csr_wdata[CFG_BLOCK_W-1:0]) > MAX_BLOCK)
                  bsize_in = CFG_BLOCK_W'(MAX_BLOCK);
               else
                  bsize_in = csr_wdata[CFG_BLOCK_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // block extent and end-of-row/column/block tests
   always_comb begin
      w_g  = GW'(width_ff);
      h_g  = GW'(height_ff);
      b_g  = GW'(bsize_ff);
      ox_g = GW'(org_x_ff);
      oy_g = GW'(org_y_ff);
      rem_x = w_g - ox_g;
      rem_y = h_g - oy_g;
      if (ox_g < w_g)
         bw_g = (rem_x < b_g) ? rem_x : b_g;
      else
         bw_g = GW'(1);
      if (oy_g < h_g)
         bh_g = (rem_y < b_g) ? rem_y : b_g;
      else
         bh_g = GW'(1);
      last_ch  = (4'(ch_pos_ff) + 4'd1) >= 4'(chan_ff);
      last_col = (GW'(col_ff) + GW'(1)) >= bw_g;
      last_row = (GW'(row_ff) + GW'(1)) >= bh_g;
      blk_end  = last_ch & last_col & last_row;
      nx_g   = ox_g + b_g;
      ny_g   = oy_g + b_g;
      wrap_x = nx_g >= w_g;
      wrap_y = ny_g >= h_g;
      x_zero = (org_x_ff == '0) && (col_ff == '0);
      y_zero = (org_y_ff == '0) && (row_ff == '0);
   end

   // position update
   always_comb begin
      ch_pos_in  = ch_pos_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      org_x_in   = org_x_ff;
      org_y_in   = org_y_ff;
      blk_cnt_in = blk_cnt_ff;
      if (accept) begin
         ch_pos_in = last_ch ? '0 : ch_pos_ff + CW'(1);
         if (last_ch) begin
            col_in = last_col ? '0 : col_ff + BW'(1);
         end
         if (last_ch && last_col) begin
            row_in = last_row ? '0 : row_ff + BW'(1);
         end
         if (blk_end) begin
            if (!wrap_x) begin
               org_x_in   = DW'(nx_g);
               blk_cnt_in = blk_cnt_ff + BLKNUM_W'(1);
            end else begin
               org_x_in = '0;
               if (wrap_y) begin
                  org_y_in   = '0;
                  blk_cnt_in = '0;
               end else begin
                  org_y_in   = DW'(ny_g);
                  blk_cnt_in = blk_cnt_ff + BLKNUM_W'(1);
               end
            end
         end
      end
   end

   // queue word
   always_comb begin
      push_valid                = accept;
      push_word.last_of_block   = blk_end;
      push_word.block_number    = blk_cnt_ff;
      push_word.raw_sample      = req_word.raw_sample;
      push_word.left_sample     = x_zero ? '0 : req_word.left_sample;
      push_word.up_sample       = y_zero ? '0 : req_word.up_sample;
      push_word.up_left_sample  = (x_zero | y_zero) ? '0 : req_word.up_left_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= CFG_DIM_W'(1);
         height_ff  <= CFG_DIM_W'(1);
         chan_ff    <= CFG_CHAN_W'(1);
         bsize_ff   <= CFG_BLOCK_W'(RESET_BLOCK);
         ch_pos_ff  <= '0;
         col_ff     <= '0;
         row_ff     <= '0;
         org_x_ff   <= '0;
         org_y_ff   <= '0;
         blk_cnt_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         chan_ff    <= chan_in;
         bsize_ff   <= bsize_in;
         ch_pos_ff  <= ch_pos_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         org_x_ff   <= org_x_in;
         org_y_ff   <= org_y_in;
         blk_cnt_ff <= blk_cnt_in;
      end
   end

endmodule
`default_nettype wire

[design/bps_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bps_queue
// Short first-in first-out queue of classified samples between the front
// and the back; the head word is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module bps_queue import bps_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire queue_word_type   push_word,
   input  wire logic             pop,
   output queue_word_type        head_word,
   output queue_status_type      q_status
);

   queue_word_type      q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push_valid & ~q_status.full;
   assign do_pop         = pop & ~q_status.empty;
   assign head_word      = q_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + QCNT_W'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push)
         q_ff[wr_ptr_ff] <= push_word;
   end

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count did not follow a push");

   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      do_pop && !do_push |=> count_ff == $past(count_ff) - QCNT_W'(1))
      else $error("queue count did not follow a pop");

endmodule
`default_nettype wire

[design/bps_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bps_back
// Runs the six predictors on each queued sample, accumulates the absolute
// errors, and at the end of a block picks the lowest score through a
// two-level compare tree into the result register.
// ----------------------------------------------------------------------------
module bps_back import bps_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire queue_word_type   head_word,
   output logic                  pop,
   bps_stream_if.source          rsp_ch
);

   typedef struct packed {
      filter_type idx;
      score_type  score;
   } cand_type;

   // pipeline advance; only a stalled result register holds it
   logic en;

   // stage 1: prediction errors
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_last_ff;
   logic [BLKNUM_W-1:0] s1_blk_ff;
   sample_type          s1_err_ff [NUM_PRED];
   sample_type          err_in    [NUM_PRED];

   // stage 2: accumulators and finished block sums
   score_type           acc_ff [NUM_PRED];
   score_type           acc_in [NUM_PRED];
   score_type           sat_sum [NUM_PRED];
   score_type           fin_ff [NUM_PRED];
   logic                fin_valid_ff, fin_valid_in;
   logic [BLKNUM_W-1:0] fin_blk_ff;

   // stage 3: pair winners
   cand_type            pair_ff [3];
   cand_type            pair_in [3];
   logic                pair_valid_ff;
   logic [BLKNUM_W-1:0] pair_blk_ff;

   // result register
   logic                rsp_valid_ff;
   cand_type            best_ff, best_in;
   logic [BLKNUM_W-1:0] rsp_blk_ff;

   sample_type l, u, ul, raw;
   sample_type p_avg, p_paeth, p_loco, mx, mn;
   logic [SAMPLE_W:0] dl, du, dul, sum_lu, two_ul;
   sample_type pred [NUM_PRED];

   function automatic sample_type abs_diff(input sample_type a, input sample_type b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic cand_type pick(input cand_type a, input cand_type b);
      return (b.score < a.score) ? b : a;
   endfunction

   assign en          = ~rsp_valid_ff | rsp_ch.ready;
   assign pop         = en;
   assign s1_valid_in = ~q_status.empty;

   // predictors
   always_comb begin
      raw = head_word.raw_sample;
      l   = head_word.left_sample;
      u   = head_word.up_sample;
      ul  = head_word.up_left_sample;
      sum_lu = (SAMPLE_W+1)'(l) + (SAMPLE_W+1)'(u);
      two_ul = {ul, 1'b0};
      p_avg  = sum_lu[SAMPLE_W:1];
      dl  = (SAMPLE_W+1)'(abs_diff(u, ul));
      du  = (SAMPLE_W+1)'(abs_diff(l, ul));
      dul = (sum_lu > two_ul) ? sum_lu - two_ul : two_ul - sum_lu;
      if (dl <= du && dl <= dul)
         p_paeth = l;
      else if (du <= dul)
         p_paeth = u;
      else
         p_paeth = ul;
      mx = (l > u) ? l : u;
      mn = (l < u) ? l : u;
      if (ul >= mx)
         p_loco = mn;
      else if (ul <= mn)
         p_loco = mx;
      else
         p_loco = SAMPLE_W'(sum_lu - (SAMPLE_W+1)'(ul));
      pred[FILTER_NONE]  = '0;
      pred[FILTER_LEFT]  = l;
      pred[FILTER_UP]    = u;
      pred[FILTER_AVG]   = p_avg;
      pred[FILTER_PAETH] = p_paeth;
      pred[FILTER_LOCO]  = p_loco;
      for (int k = 0; k < NUM_PRED; k++)
         err_in[k] = abs_diff(raw, pred[k]);
   end

   // saturating accumulate, cleared after the last sample of a block
   always_comb begin
      logic [SCORE_W:0] sum;
      for (int k = 0; k < NUM_PRED; k++) begin
         sum = (SCORE_W+1)'(acc_ff[k]) + (SCORE_W+1)'(s1_err_ff[k]);
         sat_sum[k] = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
         acc_in[k]  = acc_ff[k];
         if (en && s1_valid_ff)
            acc_in[k] = s1_last_ff ? '0 : sat_sum[k];
      end
      fin_valid_in = s1_valid_ff & s1_last_ff;
   end

   // compare tree, lower index wins ties
   always_comb begin
      pair_in[0] = pick('{idx: FILTER_NONE,  score: fin_ff[FILTER_NONE]},
                        '{idx: FILTER_LEFT,  score: fin_ff[FILTER_LEFT]});
      pair_in[1] = pick('{idx: FILTER_UP,    score: fin_ff[FILTER_UP]},
                        '{idx: FILTER_AVG,   score: fin_ff[FILTER_AVG]});
      pair_in[2] = pick('{idx: FILTER_PAETH, score: fin_ff[FILTER_PAETH]},
                        '{idx: FILTER_LOCO,  score: fin_ff[FILTER_LOCO]});
      best_in = pick(pick(pair_ff[0], pair_ff[1]), pair_ff[2]);
   end

   // stage valids and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         fin_valid_ff  <= 1'b0;
         pair_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int k = 0; k < NUM_PRED; k++)
            acc_ff[k] <= '0;
      end else begin
         if (en) begin
            s1_valid_ff   <= s1_valid_in;
            fin_valid_ff  <= fin_valid_in;
            pair_valid_ff <= fin_valid_ff;
            rsp_valid_ff  <= pair_valid_ff;
         end
         for (int k = 0; k < NUM_PRED; k++)
            acc_ff[k] <= acc_in[k];
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         s1_last_ff <= head_word.last_of_block;
         s1_blk_ff  <= head_word.block_number;
         for (int k = 0; k < NUM_PRED; k++)
            s1_err_ff[k] <= err_in[k];
         if (fin_valid_in) begin
            for (int k = 0; k < NUM_PRED; k++)
               fin_ff[k] <= sat_sum[k];
            fin_blk_ff <= s1_blk_ff;
         end
         for (int p = 0; p < 3; p++)
            pair_ff[p] <= pair_in[p];
         pair_blk_ff <= fin_blk_ff;
         best_ff     <= best_in;
         rsp_blk_ff  <= pair_blk_ff;
      end
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.payload.best_filter  = best_ff.idx;
   assign rsp_ch.payload.block_number = rsp_blk_ff;
   assign rsp_ch.payload.best_score   = best_ff.score;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s1_valid_ff) && $stable(fin_valid_ff) && $stable(pair_valid_ff))
      else $error("back pipeline moved while the result was stalled");

   a_block_clears: assert property (@(posedge clock) disable iff (reset)
      en && s1_valid_ff && s1_last_ff |=> acc_ff[0] == '0 && acc_ff[NUM_PRED-1] == '0)
      else $error("error sums not cleared after block end");

endmodule
`default_nettype wire

[design/block_predictor_selector_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// block_predictor_selector_unit
// Per-block predictor selector: scores six sample predictors over square
// blocks and reports the best one at the end of each block.
// ----------------------------------------------------------------------------
// The unit takes one sample word per clock cycle, sustained, as long as the
// result side keeps up. The front classifies each sample in the cycle it is
// accepted and writes it into a four-word queue; the back computes all six
// predictors in one stage and updates the six error sums in the next, so one
// sample per cycle is the rate set by that predictor stage and accumulator
// stage. With the queue empty, a block's result, after the clock edge that
// accepts the block's last sample, passes through the prediction, accumulation,
// pair compare and result registers behind the queue to the result channel.
// While a result waits, the back holds and the queue keeps taking
// samples until it is full. Configuration writes take effect on the next
// sample and may only be issued while the unit is idle.
// ----------------------------------------------------------------------------
module block_predictor_selector_unit import bps_pkg::*; #(
   parameter int MAX_DIM      = 4096,
   parameter int MAX_BLOCK    = 64,
   parameter int MAX_CHANNELS = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   bps_stream_if.sink                  req_ch,
   bps_stream_if.source                rsp_ch
);

   queue_status_type q_status;
   logic             push_valid;
   queue_word_type   push_word;
   queue_word_type   head_word;
   logic             pop;

   bps_front #(
      .MAX_DIM      (MAX_DIM),
      .MAX_BLOCK    (MAX_BLOCK),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_ch     (req_ch),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_word  (push_word)
   );

   bps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pop        (pop),
      .head_word  (head_word),
      .q_status   (q_status)
   );

   bps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_word (head_word),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for block_predictor_selector_unit. Sample words go in
// with random gaps; every accepted word runs through a scoring model kept in
// the bench. Each block result is compared field by field with the oldest
// predicted choice. Covers reset geometry, every predictor winning, ties,
// border zeroing, partial blocks, geometry changes mid-image, a long result
// stall and a random image sweep.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bps_pkg::*;

   localparam int MAX_DIM        = 4096;
   localparam int MAX_BLOCK      = 64;
   localparam int MAX_CHANNELS   = 4;
   localparam int DIM_ALL_ONES   = (1 << CFG_DIM_W) - 1;
   localparam int BLOCK_ALL_ONES = (1 << CFG_BLOCK_W) - 1;
   localparam int IDLE_PCT       = 9;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_WORDS   = 300;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bps_stream_if #(.payload_type(req_payload_type)) req_bus ();
   bps_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   block_predictor_selector_unit #(
      .MAX_DIM      (MAX_DIM),
      .MAX_BLOCK    (MAX_BLOCK),
      .MAX_CHANNELS (MAX_CHANNELS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   // shadow registers, as written
   int geo_width  = 1;
   int geo_height = 1;
   int geo_chans  = 1;
   int geo_block  = 8;

   // scoring model state
   int at_chan    = 0;
   int at_col     = 0;
   int at_row     = 0;
   int origin_x   = 0;
   int origin_y   = 0;
   int block_idx  = 0;
   int err_sum [NUM_PRED] = '{default: 0};

   rsp_payload_type pending_choices [$];
   rsp_payload_type want;
   int  fail_count   = 0;
   int  quiet_cycles = 0;
   bit  source_idle_on    = 1'b1;
   bit  sink_idle_on      = 1'b1;
   bit  sink_hold_request = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int bounded(input int v, input int top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // Score one sample word; returns 1 when it closes a block and fills r.
   function automatic bit select_predictor(input req_payload_type s,
                                           output rsp_payload_type r);
      int w, h, c, b, x, y, raw, l, u, ul, bw, bh, hi, lo, da, db, dc;
      int best, sum, k;
      int guess [NUM_PRED];
      r   = '0;
      w   = bounded(geo_width, MAX_DIM);
      h   = bounded(geo_height, MAX_DIM);
      c   = bounded(geo_chans, MAX_CHANNELS);
      b   = bounded(geo_block, MAX_BLOCK);
      raw = int'(s.raw_sample);
      l   = int'(s.left_sample);
      u   = int'(s.up_sample);
      ul  = int'(s.up_left_sample);
      x   = origin_x + at_col;
      y   = origin_y + at_row;

      // neighbors outside the image read as zero
      if (x == 0) begin
         l  = 0;
         ul = 0;
      end
      if (y == 0) begin
         u  = 0;
         ul = 0;
      end

      guess[FILTER_NONE] = 0;
      guess[FILTER_LEFT] = l;
      guess[FILTER_UP]   = u;
      guess[FILTER_AVG]  = (l + u) / 2;

      // Paeth: neighbor closest to l + u - ul, left first, then up
      da = magnitude(u - ul);
      db = magnitude(l - ul);
      dc = magnitude(l + u - 2 * ul);
      if (da <= db && da <= dc) begin
         guess[FILTER_PAETH] = l;
      end else if (db <= dc) begin
         guess[FILTER_PAETH] = u;
      end else begin
         guess[FILTER_PAETH] = ul;
      end

      // median edge detector
      hi = (l > u) ? l : u;
      lo = (l < u) ? l : u;
      if (ul >= hi) begin
         guess[FILTER_LOCO] = lo;
      end else if (ul <= lo) begin
         guess[FILTER_LOCO] = hi;
      end else begin
         guess[FILTER_LOCO] = l + u - ul;
      end

      for (k = 0; k < NUM_PRED; k++) begin
         sum        = err_sum[k] + magnitude(raw - guess[k]);
         err_sum[k] = (sum > int'(SCORE_MAX)) ? int'(SCORE_MAX) : sum;
      end

      // block extent; an origin past the image edge is a one-pixel block
      bw = (origin_x < w) ? ((w - origin_x < b) ? w - origin_x : b) : 1;
      bh = (origin_y < h) ? ((h - origin_y < b) ? h - origin_y : b) : 1;

      // counters at or past their limit count as at their last value
      if (at_chan + 1 < c) begin
         at_chan++;
         return 1'b0;
      end
      at_chan = 0;
      if (at_col + 1 < bw) begin
         at_col++;
         return 1'b0;
      end
      at_col = 0;
      if (at_row + 1 < bh) begin
         at_row++;
         return 1'b0;
      end
      at_row = 0;

      // lowest sum wins, lower index on ties
      best = int'(FILTER_NONE);
      for (k = 1; k < NUM_PRED; k++)
         if (err_sum[k] < err_sum[best]) best = k;
      r.best_filter  = filter_type'(best);
      r.block_number = BLKNUM_W'(block_idx);
      r.best_score   = SCORE_W'(err_sum[best]);
      for (k = 0; k < NUM_PRED; k++) err_sum[k] = 0;

      // next block; wrap to the first block after the image ends
      origin_x += b;
      if (origin_x >= w) begin
         origin_x  = 0;
         origin_y += b;
         if (origin_y >= h) begin
            origin_y  = 0;
            block_idx = 0;
            return 1'b1;
         end
      end
      block_idx = (block_idx + 1) % (1 << BLKNUM_W);
      return 1'b1;
   endfunction

   // Random word: half pure noise, half smooth content near one predictor.
   function automatic req_payload_type random_sample();
      req_payload_type s;
      int target;
      s = $urandom;
      if ($urandom_range(1) == 1) begin
         case ($urandom_range(3))
            0:       target = int'(s.left_sample);
            1:       target = int'(s.up_sample);
            2:       target = (int'(s.left_sample) + int'(s.up_sample)) / 2;
            default: target = int'(s.left_sample) + int'(s.up_sample)
                              - int'(s.up_left_sample);
         endcase
         target += int'($urandom_range(6)) - 3;
         if (target < 0) target = 0;
         else if (target > 255) target = 255;
         s.raw_sample = sample_type'(target);
      end
      return s;
   endfunction

   // Send one word; valid stays high across back-to-back words.
   task automatic send_sample(input req_payload_type s);
      rsp_payload_type choice;
      while (source_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= s;
      do @(posedge clock); while (!req_bus.ready);
      if (select_predictor(s, choice)) pending_choices.push_back(choice);
      @(negedge clock);
   endtask

   task automatic send_fields(input int raw, input int l, input int u, input int ul);
      send_sample(req_payload_type'{sample_type'(raw), sample_type'(l),
                                    sample_type'(u), sample_type'(ul)});
   endtask

   // Stop sending, wait for every block result, then let trailing words drain.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_choices.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the selected geometry registers; unused upper data bits of the channel and block writes are random.
   task automatic configure(input int w, input int h, input int c, input int b,
                            input bit [3:0] which);
      logic [CSR_DATA_W-1:0] data;
      int i;
      for (i = 0; i < 4; i++) begin
         if (which[i]) begin
            data = CSR_DATA_W'($urandom);
            case (reg_index_type'(i))
               REG_IMAGE_WIDTH: begin
                  data      = CSR_DATA_W'(w);
                  geo_width = int'(data);
               end
               REG_IMAGE_HEIGHT: begin
                  data       = CSR_DATA_W'(h);
                  geo_height = int'(data);
               end
               REG_CHANNEL_COUNT: begin
                  data[CFG_CHAN_W-1:0] = CFG_CHAN_W'(c);
                  geo_chans            = int'(data[CFG_CHAN_W-1:0]);
               end
               REG_BLOCK_SIZE: begin
                  data[CFG_BLOCK_W-1:0] = CFG_BLOCK_W'(b);
                  geo_block             = int'(data[CFG_BLOCK_W-1:0]);
               end
               default: ;
            endcase
            csr_we    <= 1'b1;
            csr_index <= reg_index_type'(i);
            csr_wdata <= data;
            @(negedge clock);
         end
      end
      csr_we <= 1'b0;
   endtask

   // Reset geometry: every word is a one-pixel image, neighbors all zeroed.
   task automatic test_reset_defaults();
      send_fields(255, 255, 255, 255);
      settle();
   endtask

   // One-pixel blocks in a 2-wide image: each interior word picks a winner.
   task automatic test_filter_choice();
      int row;
      configure(2, 8, 1, 1, 4'hF);
      send_fields(0, 255, 255, 255);
      send_fields(255, 0, 255, 0);
      for (row = 1; row < 8; row++) begin
         send_fields(0, 255, 255, 255);
         case (row)
            1: send_fields(0, 200, 180, 190);     // zero predictor wins
            2: send_fields(200, 200, 10, 100);    // left wins
            3: send_fields(200, 10, 200, 100);    // up wins
            4: send_fields(150, 100, 200, 0);     // average wins
            5: send_fields(100, 200, 10, 100);    // Paeth wins
            6: send_fields(110, 200, 10, 100);    // median wins
            default: send_fields(50, 50, 50, 50); // tie, lowest index wins
         endcase
      end
      settle();
   endtask

   // Shrink width and channels mid-block: origin past the edge, counters
   // past their new limits.
   task automatic test_reconfig_midstream();
      configure(8, 4, 2, 2, 4'hF);
      repeat (11) send_sample(random_sample());
      settle();
      configure(1, 0, 1, 0, 4'b0101);
      repeat (2) send_sample(random_sample());
      settle();
   endtask

   // Result side stalls for a long stretch while words keep coming.
   task automatic test_backpressure();
      configure(16, 16, 1, 1, 4'hF);
      source_idle_on    = 1'b0;
      sink_idle_on      = 1'b0;
      sink_hold_request = 1'b1;
      repeat (40) send_sample(random_sample());
      settle();
      source_idle_on = 1'b1;
      sink_idle_on   = 1'b1;
   endtask

   // Random geometries, mostly small whole images, some extremes and cut-offs.
   task automatic test_random_images();
      int sent, n, w, h, c, b;
      bit [3:0] which;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         source_idle_on = ($urandom_range(3) != 0);
         sink_idle_on   = ($urandom_range(3) != 0);
         if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
               0:       w = 0;
               1:       w = MAX_DIM;
               2:       w = DIM_ALL_ONES;
               default: w = $urandom_range(0, DIM_ALL_ONES);
            endcase
            h = ($urandom_range(1) == 1) ? DIM_ALL_ONES : $urandom_range(0, 4);
            c = $urandom_range(0, 7);
            case ($urandom_range(3))
               0:       b = 0;
               1:       b = MAX_BLOCK;
               2:       b = BLOCK_ALL_ONES;
               default: b = $urandom_range(0, BLOCK_ALL_ONES);
            endcase
         end else begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            c = $urandom_range(1, MAX_CHANNELS);
            b = $urandom_range(1, 4);
         end
         which = ($urandom_range(4) == 0) ? 4'($urandom) : 4'hF;
         configure(w, h, c, b, which);
         n = bounded(geo_width, MAX_DIM) * bounded(geo_height, MAX_DIM)
             * bounded(geo_chans, MAX_CHANNELS);
         if ($urandom_range(3) == 0) n = $urandom_range(1, 30);
         else if (n > 150) n = $urandom_range(40, 150);
         repeat (n) send_sample(random_sample());
         sent += n;
         settle();
      end
      source_idle_on = 1'b1;
      sink_idle_on   = 1'b1;
   endtask

   // result side ready, with random gaps and an on-demand long hold
   initial begin : result_sink
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            hold_left         = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !(sink_idle_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // compare each result word with the oldest predicted choice
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_choices.size() == 0) begin
            $error("block result with none predicted: filter %0d block %0d score %0d",
                   rsp_bus.payload.best_filter, rsp_bus.payload.block_number,
                   rsp_bus.payload.best_score);
            fail_count++;
         end else begin
            want = pending_choices.pop_front();
            if (rsp_bus.payload.best_filter !== want.best_filter) begin
               $error("best_filter mismatch: expected %0d, got %0d",
                      want.best_filter, rsp_bus.payload.best_filter);
               fail_count++;
            end
            if (rsp_bus.payload.block_number !== want.block_number) begin
               $error("block_number mismatch: expected %0d, got %0d",
                      want.block_number, rsp_bus.payload.block_number);
               fail_count++;
            end
            if (rsp_bus.payload.best_score !== want.best_score) begin
               $error("best_score mismatch: expected %0d, got %0d",
                      want.best_score, rsp_bus.payload.best_score);
               fail_count++;
            end
         end
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("block_predictor_selector_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = REG_IMAGE_WIDTH;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_filter_choice();
      test_reconfig_midstream();
      test_backpressure();
      test_random_images();

      if (pending_choices.size() != 0) begin
         $error("%0d block results never arrived", pending_choices.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("block_predictor_selector_unit test passed");
      end else begin
         $display("block_predictor_selector_unit test failed");
      end
      $finish;
   end

endmodule

[files.f]
design/bps_pkg.sv
design/bps_stream_if.sv
design/bps_front.sv
design/bps_queue.sv
design/bps_back.sv
design/block_predictor_selector_unit.sv
dv/testbench.sv
